### design/apec_pkg.sv
// shared widths, command codes and constants of the peak envelope capture block
package apec_pkg;

  localparam int CMD_W   = 2;
  localparam int LEVEL_W = 8;
  localparam int INDEX_W = 9;
  localparam int COUNT_W = 10;
  localparam int SHIFT_W = 4;
  localparam int PEND_W  = 16;

  localparam int MIN_LIMIT = 2;

  localparam logic [COUNT_W-1:0] MAX_COLS_RESET = 10'd400;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX      = 4'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } apec_cmd_e;

endpackage

### design/apec_in_if.sv
// command item channel into the peak envelope capture block
interface apec_in_if;
  logic                         valid;
  logic                         ready;
  logic [apec_pkg::CMD_W-1:0]   cmd;
  logic [apec_pkg::LEVEL_W-1:0] level;
  logic [apec_pkg::INDEX_W-1:0] index;

  modport source (output valid, cmd, level, index, input ready);
  modport sink   (input valid, cmd, level, index, output ready);
endinterface

### design/apec_out_if.sv
// result item channel out of the peak envelope capture block
interface apec_out_if;
  logic                         valid;
  logic                         ready;
  logic [apec_pkg::LEVEL_W-1:0] column_value;
  logic                         column_valid;
  logic [apec_pkg::COUNT_W-1:0] column_count;
  logic [apec_pkg::SHIFT_W-1:0] merge_shift;
  logic                         column_written;

  modport source (output valid, column_value, column_valid, column_count, merge_shift,
                  column_written, input ready);
  modport sink   (input valid, column_value, column_valid, column_count, merge_shift,
                  column_written, output ready);
endinterface

### design/apec_store.sv
// column store: one write port and two registered read ports
module apec_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [apec_pkg::LEVEL_W-1:0] wdata_i,
  input  logic [AW-1:0]                raddr_a_i,
  input  logic [AW-1:0]                raddr_b_i,
  output logic [apec_pkg::LEVEL_W-1:0] rdata_a_o,
  output logic [apec_pkg::LEVEL_W-1:0] rdata_b_o
);
  import apec_pkg::*;

  logic [LEVEL_W-1:0] mem [DEPTH];
  logic [LEVEL_W-1:0] rdata_a_q;
  logic [LEVEL_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### design/adaptive_peak_envelope_capture.sv
// peak envelope capture: top level with command sequencer and column store
// A push that stores no column, or stores one while the store has room, a clear and the
// unused command each give their result in the cycle after acceptance, and the next item
// can follow in the next cycle once that result is taken. A read passes through the READ
// state while the store's registered read port returns the level. A push that closes a
// column while the store is at its limit first compacts the store: one adjacent pair is
// read per cycle through the two read ports and its maximum written back in the next cycle.
// Nothing is accepted while an item is in work. No clearing pass follows reset.
module adaptive_peak_envelope_capture #(
  parameter int MAX_COLUMNS = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [apec_pkg::COUNT_W-1:0] cfg_wdata_i,
  apec_in_if.sink                      in_i,
  apec_out_if.source                   out_o
);
  import apec_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int AW = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
  localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      half_q, half_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [SHIFT_W-1:0] exp_q, exp_d;
  logic [LEVEL_W-1:0] peak_q, peak_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [COUNT_W-1:0] max_cols_q;
  logic               rd_valid_q, rd_valid_d;
  logic               wr_pend_q, wr_pend_d;
  logic [AW-1:0]      wr_idx_q, wr_idx_d;

  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] value_q, value_d;
  logic               cvalid_q, cvalid_d;
  logic [COUNT_W-1:0] ccount_q, ccount_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic               written_q, written_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [LEVEL_W-1:0] mem_wdata;
  logic [AW-1:0]      raddr_a, raddr_b;
  logic [LEVEL_W-1:0] rdata_a, rdata_b;

  logic [WW-1:0]      lim;
  logic [WW-1:0]      count_w;
  logic               in_acc;
  logic [LEVEL_W-1:0] peak_new;
  logic [PEND_W-1:0]  pend_new;
  logic               full;
  logic [LEVEL_W-1:0] pair_max;
  logic               out_load;
  logic [LEVEL_W-1:0] res_value;
  logic               res_valid;
  logic               res_written;

  apec_store #(
    .DEPTH (MAX_COLUMNS),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // effective column limit
  always_comb begin
    if (max_cols_q < COUNT_W'(MIN_LIMIT)) begin
      lim = WW'(MIN_LIMIT);
    end else if (WW'(max_cols_q) > WW'(MAX_COLUMNS)) begin
      lim = WW'(MAX_COLUMNS);
    end else begin
      lim = WW'(max_cols_q);
    end
  end

  assign count_w  = WW'(count_q);
  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc   = in_i.valid && in_i.ready;
  assign peak_new = (in_i.level > peak_q) ? in_i.level : peak_q;
  assign pend_new = pend_q + PEND_W'(1);
  assign full     = pend_new >= (PEND_W'(1) << exp_q);
  assign pair_max = (rdata_a > rdata_b) ? rdata_a : rdata_b;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    half_d      = half_q;
    ptr_d       = ptr_q;
    exp_d       = exp_q;
    peak_d      = peak_q;
    pend_d      = pend_q;
    rd_valid_d  = rd_valid_q;
    wr_pend_d   = wr_pend_q;
    wr_idx_d    = wr_idx_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(count_q);
    mem_wdata   = peak_new;
    raddr_a     = AW'(in_i.index);
    raddr_b     = '0;
    out_load    = 1'b0;
    res_value   = '0;
    res_valid   = 1'b0;
    res_written = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (apec_cmd_e'(in_i.cmd))
            CMD_PUSH: begin
              peak_d = peak_new;
              pend_d = pend_new;
              if (!full) begin
                out_load = 1'b1;
              end else if (count_w >= lim) begin
                state_d   = ST_CMP;
                half_d    = count_q >> 1;
                ptr_d     = '0;
                wr_pend_d = 1'b0;
              end else begin
                mem_we      = 1'b1;
                count_d     = count_q + CW'(1);
                peak_d      = '0;
                pend_d      = '0;
                out_load    = 1'b1;
                res_written = 1'b1;
              end
            end
            CMD_READ: begin
              rd_valid_d = WW'(in_i.index) < count_w;
              state_d    = ST_READ;
            end
            CMD_CLEAR: begin
              count_d  = '0;
              exp_d    = '0;
              peak_d   = '0;
              pend_d   = '0;
              out_load = 1'b1;
            end
            CMD_NOP: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load  = 1'b1;
        res_value = rd_valid_q ? rdata_a : '0;
        res_valid = rd_valid_q;
        state_d   = ST_IDLE;
      end
      ST_CMP: begin
        raddr_a = AW'({ptr_q, 1'b0});
        raddr_b = AW'({ptr_q, 1'b1});
        if (wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_q;
          mem_wdata = pair_max;
        end
        if (ptr_q == half_q) begin
          wr_pend_d = 1'b0;
          state_d   = ST_FIN;
        end else begin
          wr_pend_d = 1'b1;
          wr_idx_d  = AW'(ptr_q);
          ptr_d     = ptr_q + CW'(1);
        end
      end
      ST_FIN: begin
        mem_we      = 1'b1;
        mem_waddr   = AW'(half_q);
        mem_wdata   = peak_q;
        count_d     = half_q + CW'(1);
        exp_d       = (exp_q == SHIFT_MAX) ? SHIFT_MAX : exp_q + SHIFT_W'(1);
        peak_d      = '0;
        pend_d      = '0;
        out_load    = 1'b1;
        res_written = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && !out_o.ready);
    value_d     = out_load ? res_value : value_q;
    cvalid_d    = out_load ? res_valid : cvalid_q;
    ccount_d    = out_load ? COUNT_W'(count_d) : ccount_q;
    shift_d     = out_load ? exp_d : shift_q;
    written_d   = out_load ? res_written : written_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      half_q      <= '0;
      ptr_q       <= '0;
      exp_q       <= '0;
      peak_q      <= '0;
      pend_q      <= '0;
      max_cols_q  <= MAX_COLS_RESET;
      rd_valid_q  <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      half_q      <= half_d;
      ptr_q       <= ptr_d;
      exp_q       <= exp_d;
      peak_q      <= peak_d;
      pend_q      <= pend_d;
      rd_valid_q  <= rd_valid_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_cols_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q  <= wr_idx_d;
    value_q   <= value_d;
    cvalid_q  <= cvalid_d;
    ccount_q  <= ccount_d;
    shift_q   <= shift_d;
    written_q <= written_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.column_value   = value_q;
  assign out_o.column_valid   = cvalid_q;
  assign out_o.column_count   = ccount_q;
  assign out_o.merge_shift    = shift_q;
  assign out_o.column_written = written_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_COLUMNS))
    else $error("column count beyond store depth");

  a_pend_below_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> pend_q < (PEND_W'(1) << exp_q))
    else $error("pending levels reached merge factor without a column");

  a_cmp_write_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) && wr_pend_q |-> CW'(wr_idx_q) < ptr_q)
    else $error("compaction write overtook its read");

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |=> out_valid_q && written_q && (state_q == ST_IDLE))
    else $error("compaction ended without a written column item");

endmodule
